/* hdl/bbh_pkg.sv */
// ----------------------------------------------------------------------------
// bbh_pkg
// Shared types and codes for the byte bigram histogram core.
// ----------------------------------------------------------------------------
package bbh_pkg;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_ARGMAX = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic       packet_start;
        logic [7:0] query_row;
        logic [7:0] query_col;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pair_count;
        logic [7:0]  row_argmax;
        logic [31:0] descending_total;
    } out_item_t;

    typedef enum logic [1:0] {
        RD_PAIR  = 2'd0,
        RD_QUERY = 2'd1,
        RD_SCAN  = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    clear_we;
        logic    load;
        logic    push_update;
        logic    read_capture;
        logic    scan_issue;
        logic    out_load;
        rd_sel_t rd_sel;
    } bbh_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_last;
        logic out_free;
    } bbh_sts_t;

endpackage

/* hdl/byte_bigram_histogram_core.sv */
// ----------------------------------------------------------------------------
// byte_bigram_histogram_core
// Byte-pair histogram over a packet byte stream with counter and row argmax
// queries; saturating counters and a running count of descending pairs.
// ----------------------------------------------------------------------------
//  channel  ports                      payload
//  input    s_valid s_ready s_data     in_item_t  (operation, byte, start, row, col)
//  result   m_valid m_ready m_data     out_item_t (count, argmax, descending total)
//
//  Argmax makes one store read per column through the single read port;
//  an unused code goes straight to the result step.
//  After reset, a clearing pass zeroes the store, one entry per cycle;
//  s_ready stays low until it ends.
//  A new item is taken while the previous result waits in the output register.
//  A stalled result blocks only the next item's final step.
// ----------------------------------------------------------------------------
module byte_bigram_histogram_core
    import bbh_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int COUNT_BITS   = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    bbh_cmd_t cmd;
    bbh_sts_t sts;

    bbh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op      (s_data.operation),
        .sts     (sts),
        .cmd     (cmd)
    );

    bbh_datapath #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* hdl/bbh_ram.sv */
// ----------------------------------------------------------------------------
// bbh_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/bbh_ctrl.sv */
// ----------------------------------------------------------------------------
// bbh_ctrl
// Sequencer: clearing pass, item dispatch, counter update, row scan, result.
// ----------------------------------------------------------------------------
module bbh_ctrl
    import bbh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] op,
    input  bbh_sts_t   sts,
    output bbh_cmd_t   cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_PUSH_RD = 9'b000000100,
        ST_PUSH_WR = 9'b000001000,
        ST_READ_RD = 9'b000010000,
        ST_READ_WR = 9'b000100000,
        ST_SCAN    = 9'b001000000,
        ST_DRAIN   = 9'b010000000,
        ST_RESULT  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_PAIR;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_we = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (op)
                        OP_PUSH:   state_next = ST_PUSH_RD;
                        OP_READ:   state_next = ST_READ_RD;
                        OP_ARGMAX: state_next = ST_SCAN;
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end
            ST_PUSH_RD: begin
                cmd.rd_sel = RD_PAIR;
                state_next = ST_PUSH_WR;
            end
            ST_PUSH_WR: begin
                cmd.push_update = 1'b1;
                state_next      = ST_RESULT;
            end
            ST_READ_RD: begin
                cmd.rd_sel = RD_QUERY;
                state_next = ST_READ_WR;
            end
            ST_READ_WR: begin
                cmd.read_capture = 1'b1;
                state_next       = ST_RESULT;
            end
            ST_SCAN: begin
                cmd.rd_sel     = RD_SCAN;
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/bbh_datapath.sv */
// ----------------------------------------------------------------------------
// bbh_datapath
// Counter store, item register, saturating update, row scan and output stage.
// ----------------------------------------------------------------------------
module bbh_datapath
    import bbh_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int COUNT_BITS   = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  bbh_cmd_t  cmd,
    output bbh_sts_t  sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int DEPTH  = SYMBOL_COUNT * SYMBOL_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SYM_W  = $clog2(SYMBOL_COUNT);

    function automatic logic [SYM_W-1:0] fold(input logic [7:0] b);
        logic [15:0] v;
        v = {8'd0, b};
        for (int k = 7; k >= 0; k--) begin
            if (v >= (16'(SYMBOL_COUNT) << k)) begin
                v = v - (16'(SYMBOL_COUNT) << k);
            end
        end
        return SYM_W'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] pair_addr(input logic [SYM_W-1:0] r,
                                                    input logic [SYM_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(SYMBOL_COUNT) + ADDR_W'(c));
    endfunction

    in_item_t              item_reg;
    logic [7:0]            prev_byte_reg;
    logic                  prev_valid_reg;
    logic [COUNT_BITS-1:0] desc_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [SYM_W-1:0]      scan_col_reg;
    logic                  cmp_en_reg;
    logic [SYM_W-1:0]      cmp_col_reg;
    logic [COUNT_BITS-1:0] best_reg;
    logic [SYM_W-1:0]      arg_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    logic                  form_pair;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] sat_data;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ADDR_W-1:0]     push_addr;

    assign form_pair = !item_reg.packet_start && prev_valid_reg;
    assign push_addr = pair_addr(fold(prev_byte_reg), fold(item_reg.byte_value));
    assign sat_data  = (&rd_data) ? rd_data : rd_data + 1'b1;

    assign ram_we    = cmd.clear_we || (cmd.push_update && form_pair);
    assign ram_waddr = cmd.clear_we ? clr_cnt_reg : push_addr;
    assign ram_wdata = cmd.clear_we ? '0 : sat_data;

    always_comb begin
        case (cmd.rd_sel)
            RD_PAIR:  ram_raddr = push_addr;
            RD_QUERY: ram_raddr = pair_addr(fold(item_reg.query_row),
                                            fold(item_reg.query_col));
            RD_SCAN:  ram_raddr = pair_addr(fold(item_reg.query_row), scan_col_reg);
            default:  ram_raddr = push_addr;
        endcase
    end

    bbh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign sts.clear_done = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign sts.scan_last  = (scan_col_reg == SYM_W'(SYMBOL_COUNT - 1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
            desc_reg       <= '0;
            clr_cnt_reg    <= '0;
            cmp_en_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clear_we) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.push_update) begin
                if (form_pair && (prev_byte_reg > item_reg.byte_value) && !(&desc_reg)) begin
                    desc_reg <= desc_reg + 1'b1;
                end
                prev_byte_reg  <= item_reg.byte_value;
                prev_valid_reg <= 1'b1;
            end
            cmp_en_reg <= cmd.scan_issue;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg     <= s_data;
            best_reg     <= '0;
            arg_reg      <= '0;
            scan_col_reg <= '0;
        end else begin
            if (cmd.scan_issue) begin
                scan_col_reg <= scan_col_reg + 1'b1;
            end
            if (cmd.read_capture) begin
                best_reg <= rd_data;
            end else if (cmp_en_reg && (rd_data > best_reg)) begin
                best_reg <= rd_data;
                arg_reg  <= cmp_col_reg;
            end
        end
        cmp_col_reg <= scan_col_reg;
        if (cmd.out_load) begin
            m_data_reg.pair_count       <= 32'(best_reg);
            m_data_reg.row_argmax       <= 8'(arg_reg);
            m_data_reg.descending_total <= 32'(desc_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
